@@ hw/rtl/rau_pkg.sv @@
package rau_pkg;

  localparam int UPC_W = 4;
  localparam int NUM_W = 33;
  localparam int DEN_W = 31;

  typedef logic [UPC_W-1:0] upc_t;
  typedef logic [3:0]       uop_t;
  typedef logic [2:0]       ucond_t;
  typedef logic [1:0]       cmd_t;

  localparam cmd_t CMD_ADD = 2'd0;
  localparam cmd_t CMD_SUB = 2'd1;
  localparam cmd_t CMD_MUL = 2'd2;
  localparam cmd_t CMD_DIV = 2'd3;

  localparam uop_t OP_NOP    = 4'd0;
  localparam uop_t OP_LOAD   = 4'd1;
  localparam uop_t OP_MUL0   = 4'd2;
  localparam uop_t OP_MUL1   = 4'd3;
  localparam uop_t OP_MUL2   = 4'd4;
  localparam uop_t OP_COMB   = 4'd5;
  localparam uop_t OP_GINIT  = 4'd6;
  localparam uop_t OP_GEVEN  = 4'd7;
  localparam uop_t OP_GSTEP  = 4'd8;
  localparam uop_t OP_GSHIFT = 4'd9;
  localparam uop_t OP_DINITN = 4'd10;
  localparam uop_t OP_DSTEP  = 4'd11;
  localparam uop_t OP_DSAVE  = 4'd12;
  localparam uop_t OP_DINITD = 4'd13;
  localparam uop_t OP_EMIT   = 4'd14;

  localparam ucond_t COND_NEVER    = 3'd0;
  localparam ucond_t COND_NO_IN    = 3'd1;
  localparam ucond_t COND_DEN_ZERO = 3'd2;
  localparam ucond_t COND_EVEN     = 3'd3;
  localparam ucond_t COND_U_NZ     = 3'd4;
  localparam ucond_t COND_K_NZ     = 3'd5;
  localparam ucond_t COND_CNT_NZ   = 3'd6;
  localparam ucond_t COND_OUT_BUSY = 3'd7;

  localparam upc_t UPC_WAIT   = 4'd0;
  localparam upc_t UPC_MUL0   = 4'd1;
  localparam upc_t UPC_MUL1   = 4'd2;
  localparam upc_t UPC_MUL2   = 4'd3;
  localparam upc_t UPC_COMB   = 4'd4;
  localparam upc_t UPC_GINIT  = 4'd5;
  localparam upc_t UPC_GEVEN  = 4'd6;
  localparam upc_t UPC_GSTEP  = 4'd7;
  localparam upc_t UPC_GSHIFT = 4'd8;
  localparam upc_t UPC_DINITN = 4'd9;
  localparam upc_t UPC_DLOOPN = 4'd10;
  localparam upc_t UPC_DSAVE  = 4'd11;
  localparam upc_t UPC_DINITD = 4'd12;
  localparam upc_t UPC_DLOOPD = 4'd13;
  localparam upc_t UPC_SPARE  = 4'd14;
  localparam upc_t UPC_EMIT   = 4'd15;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    upc_t   target;
  } ctrl_word_t;

  typedef struct packed {
    logic no_in;
    logic den_zero;
    logic both_even;
    logic u_nz;
    logic k_nz;
    logic cnt_nz;
    logic out_busy;
  } rau_flags_t;

  function automatic ctrl_word_t ucode_rom(input upc_t addr);
    ctrl_word_t w;
    begin
      w = '{op: OP_NOP, cond: COND_NEVER, target: UPC_WAIT};
      case (addr)
        UPC_WAIT:   w = '{op: OP_LOAD,   cond: COND_NO_IN,    target: UPC_WAIT};
        UPC_MUL0:   w = '{op: OP_MUL0,   cond: COND_NEVER,    target: UPC_WAIT};
        UPC_MUL1:   w = '{op: OP_MUL1,   cond: COND_NEVER,    target: UPC_WAIT};
        UPC_MUL2:   w = '{op: OP_MUL2,   cond: COND_NEVER,    target: UPC_WAIT};
        UPC_COMB:   w = '{op: OP_COMB,   cond: COND_DEN_ZERO, target: UPC_EMIT};
        UPC_GINIT:  w = '{op: OP_GINIT,  cond: COND_NEVER,    target: UPC_WAIT};
        UPC_GEVEN:  w = '{op: OP_GEVEN,  cond: COND_EVEN,     target: UPC_GEVEN};
        UPC_GSTEP:  w = '{op: OP_GSTEP,  cond: COND_U_NZ,     target: UPC_GSTEP};
        UPC_GSHIFT: w = '{op: OP_GSHIFT, cond: COND_K_NZ,     target: UPC_GSHIFT};
        UPC_DINITN: w = '{op: OP_DINITN, cond: COND_NEVER,    target: UPC_WAIT};
        UPC_DLOOPN: w = '{op: OP_DSTEP,  cond: COND_CNT_NZ,   target: UPC_DLOOPN};
        UPC_DSAVE:  w = '{op: OP_DSAVE,  cond: COND_NEVER,    target: UPC_WAIT};
        UPC_DINITD: w = '{op: OP_DINITD, cond: COND_NEVER,    target: UPC_WAIT};
        UPC_DLOOPD: w = '{op: OP_DSTEP,  cond: COND_CNT_NZ,   target: UPC_DLOOPD};
        UPC_SPARE:  w = '{op: OP_NOP,    cond: COND_NEVER,    target: UPC_WAIT};
        UPC_EMIT:   w = '{op: OP_EMIT,   cond: COND_OUT_BUSY, target: UPC_EMIT};
        default:    w = '{op: OP_NOP,    cond: COND_NEVER,    target: UPC_WAIT};
      endcase
      return w;
    end
  endfunction

endpackage

@@ hw/rtl/rau_useq.sv @@
module rau_useq
  import rau_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  rau_flags_t flags,
  output ctrl_word_t ctrl
);

  upc_t pc_r;
  upc_t pc_nxt;
  logic take;

  assign ctrl = ucode_rom(pc_r);

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:    take = 1'b0;
      COND_NO_IN:    take = flags.no_in;
      COND_DEN_ZERO: take = flags.den_zero;
      COND_EVEN:     take = flags.both_even;
      COND_U_NZ:     take = flags.u_nz;
      COND_K_NZ:     take = flags.k_nz;
      COND_CNT_NZ:   take = flags.cnt_nz;
      COND_OUT_BUSY: take = flags.out_busy;
      default:       take = 1'b0;
    endcase
    pc_nxt = take ? ctrl.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UPC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ hw/rtl/rational_arith_unit.sv @@
// rational_arith_unit: exact add, subtract, multiply and divide of two
// signed fractions, reduced to lowest terms with the sign on the numerator.
// input channel: in_valid/in_stall with in_cmd, in_a_num, in_a_den,
// in_b_num, in_b_den; one item is taken at a time, in_stall stays high
// from the cycle after acceptance until the result is written out.
// result channel: out_valid/out_stall with out_res_num, out_res_den and
// out_invalid; exactly one result per item, in order.
// sequence (W = OPERAND_WIDTH): after acceptance the MUL0, MUL1, MUL2 and
// COMB steps form the raw terms, then the binary gcd loop runs, then two
// restoring divisions by the gcd (numerator, then denominator), one
// quotient bit per cycle over 2*W bits each, then a spare step and the
// write-out. A zero raw denominator skips the gcd and divisions and
// returns invalid with zero fields.
// a new item is not taken before the previous one is written out; the
// microcode loops on the shared divider and the gcd subtractor set its pace.
// the output register holds a finished result while out_stall is high;
// the next item is accepted meanwhile and waits in its final step.
// reset (synchronous, rst_n low) returns the sequencer to its wait step
// and drops out_valid.
module rational_arith_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_cmd,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_den,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [NUM_W-1:0]         out_res_num,
  output logic [DEN_W-1:0]                out_res_den,
  output logic                            out_invalid
);

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * W;
  localparam int KW = $clog2(MW + 1);
  localparam int XW = (MW > NUM_W) ? MW : NUM_W;

  ctrl_word_t ctrl;
  rau_flags_t flags;

  cmd_t          cmd_r;
  logic [W-1:0]  an_r, ad_r, bn_r, bd_r;
  logic [MW-1:0] p0_mag_r, p1_mag_r, den_mag_r, num_mag_r;
  logic          p0_neg_r, p1_neg_r, den_neg_r, num_neg_r;
  logic          inv_r;
  logic [MW-1:0] u_r, v_r, rem_r, quo_r, qn_r;
  logic [KW-1:0] k_r, cnt_r;

  logic                   out_valid_r, out_valid_nxt;
  logic signed [NUM_W-1:0] out_num_r;
  logic [DEN_W-1:0]       out_den_r;
  logic                   out_inv_r;

  logic          in_acc, out_busy;
  logic [W-1:0]  mx, my, mx_mag, my_mag;
  logic [MW-1:0] prod;
  logic          prod_neg;
  logic          b_neg;
  logic [MW-1:0] sum_mag;
  logic          sum_neg;
  logic          u_ge_v;
  logic [MW-1:0] diff;
  logic [MW:0]   sh, trial;
  logic          q_bit;
  logic [XW-1:0] qn_x, qd_x, sres;
  logic          res_neg;

  rau_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign in_stall = (ctrl.op != OP_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_busy = out_valid_r && out_stall;

  assign flags.no_in     = !in_valid;
  assign flags.den_zero  = (den_mag_r == '0);
  assign flags.both_even = (u_r != '0) && !u_r[0] && !v_r[0];
  assign flags.u_nz      = (u_r != '0);
  assign flags.k_nz      = (k_r != '0);
  assign flags.cnt_nz    = (cnt_r != '0);
  assign flags.out_busy  = out_busy;

  // shared multiplier operand select
  always_comb begin
    case (ctrl.op)
      OP_MUL0: begin
        mx = an_r;
        my = (cmd_r == CMD_MUL) ? bn_r : bd_r;
      end
      OP_MUL1: begin
        mx = ad_r;
        my = bn_r;
      end
      default: begin
        mx = ad_r;
        my = (cmd_r == CMD_DIV) ? bn_r : bd_r;
      end
    endcase
    mx_mag   = mx[W-1] ? (~mx + 1'b1) : mx;
    my_mag   = my[W-1] ? (~my + 1'b1) : my;
    prod     = MW'(mx_mag) * MW'(my_mag);
    prod_neg = (mx[W-1] ^ my[W-1]) && (prod != '0);
  end

  // sign-magnitude add or subtract of the two cross products
  always_comb begin
    b_neg = p1_neg_r ^ ((cmd_r == CMD_SUB) && (p1_mag_r != '0));
    if (p0_neg_r == b_neg) begin
      sum_mag = p0_mag_r + p1_mag_r;
      sum_neg = p0_neg_r;
    end else if (p0_mag_r >= p1_mag_r) begin
      sum_mag = p0_mag_r - p1_mag_r;
      sum_neg = p0_neg_r;
    end else begin
      sum_mag = p1_mag_r - p0_mag_r;
      sum_neg = b_neg;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
  end

  assign u_ge_v = (u_r >= v_r);
  assign diff   = u_ge_v ? (u_r - v_r) : (v_r - u_r);

  // restoring divider step, divisor is the gcd held in v_r
  assign sh    = {rem_r, quo_r[MW-1]};
  assign trial = sh - {1'b0, v_r};
  assign q_bit = (sh >= {1'b0, v_r});

  assign res_neg = (num_neg_r != den_neg_r) && (qn_r != '0);
  assign qn_x    = XW'(qn_r);
  assign qd_x    = XW'(quo_r);
  assign sres    = res_neg ? (~qn_x + 1'b1) : qn_x;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (in_acc) begin
          cmd_r <= in_cmd;
          an_r  <= in_a_num;
          ad_r  <= in_a_den;
          bn_r  <= in_b_num;
          bd_r  <= in_b_den;
        end
      end
      OP_MUL0: begin
        p0_mag_r <= prod;
        p0_neg_r <= prod_neg;
      end
      OP_MUL1: begin
        p1_mag_r <= prod;
        p1_neg_r <= prod_neg;
      end
      OP_MUL2: begin
        den_mag_r <= prod;
        den_neg_r <= prod_neg;
      end
      OP_COMB: begin
        inv_r <= (den_mag_r == '0);
        if (cmd_r == CMD_ADD || cmd_r == CMD_SUB) begin
          num_mag_r <= sum_mag;
          num_neg_r <= sum_neg;
        end else begin
          num_mag_r <= p0_mag_r;
          num_neg_r <= p0_neg_r;
        end
      end
      OP_GINIT: begin
        u_r <= num_mag_r;
        v_r <= den_mag_r;
        k_r <= '0;
      end
      OP_GEVEN: begin
        if (flags.both_even) begin
          u_r <= u_r >> 1;
          v_r <= v_r >> 1;
          k_r <= k_r + 1'b1;
        end
      end
      OP_GSTEP: begin
        if (u_r != '0) begin
          if (!u_r[0]) begin
            u_r <= u_r >> 1;
          end else if (!v_r[0]) begin
            v_r <= v_r >> 1;
          end else if (u_ge_v) begin
            u_r <= diff >> 1;
          end else begin
            v_r <= diff >> 1;
          end
        end
      end
      OP_GSHIFT: begin
        if (k_r != '0) begin
          v_r <= v_r << 1;
          k_r <= k_r - 1'b1;
        end
      end
      OP_DINITN: begin
        rem_r <= '0;
        quo_r <= num_mag_r;
        cnt_r <= KW'(MW);
      end
      OP_DSTEP: begin
        if (cnt_r != '0) begin
          rem_r <= q_bit ? trial[MW-1:0] : sh[MW-1:0];
          quo_r <= {quo_r[MW-2:0], q_bit};
          cnt_r <= cnt_r - 1'b1;
        end
      end
      OP_DSAVE: begin
        qn_r <= quo_r;
      end
      OP_DINITD: begin
        rem_r <= '0;
        quo_r <= den_mag_r;
        cnt_r <= KW'(MW);
      end
      OP_EMIT: begin
        if (!out_busy) begin
          out_inv_r <= inv_r;
          out_num_r <= inv_r ? '0 : sres[NUM_W-1:0];
          out_den_r <= inv_r ? '0 : qd_x[DEN_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.op == OP_EMIT && !out_busy) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_res_num = out_num_r;
  assign out_res_den = out_den_r;
  assign out_invalid = out_inv_r;

`ifndef ASSERT_OFF
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_inv_r |-> (out_num_r == '0) && (out_den_r == '0))
    else $error("invalid result with nonzero fields");

  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_DSTEP) |-> (v_r != '0))
    else $error("divider running with zero divisor");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.op == OP_EMIT))
    else $error("result raised outside the write-out step");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_num_r) && $stable(out_den_r))
    else $error("stalled result changed");
`endif

endmodule

@@ tb/rational_arith_unit_tb.sv @@
module rational_arith_unit_tb
  import rau_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OW = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1200;

  typedef logic signed [OW-1:0] opnd_t;

  localparam opnd_t SMIN = -32768;
  localparam opnd_t SMAX = 32767;

  typedef struct {
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
    logic                    invalid;
  } fraction_t;

  class fraction_checker;
    fraction_t pending_fractions[$];
    int        mismatches;

    function fraction_t reduce_fraction(cmd_t op, opnd_t an, opnd_t ad, opnd_t bn, opnd_t bd);
      longint    n, d, u, v, t;
      fraction_t f;
      case (op)
        CMD_ADD: begin
          n = longint'(an) * longint'(bd) + longint'(ad) * longint'(bn);
          d = longint'(ad) * longint'(bd);
        end
        CMD_SUB: begin
          n = longint'(an) * longint'(bd) - longint'(ad) * longint'(bn);
          d = longint'(ad) * longint'(bd);
        end
        CMD_MUL: begin
          n = longint'(an) * longint'(bn);
          d = longint'(ad) * longint'(bd);
        end
        default: begin
          n = longint'(an) * longint'(bd);
          d = longint'(ad) * longint'(bn);
        end
      endcase
      f.num = '0;
      f.den = '0;
      f.invalid = 1'b1;
      if (d != 0) begin
        // euclid on the magnitudes, sign goes on the numerator
        u = (n < 0) ? -n : n;
        v = (d < 0) ? -d : d;
        while (v != 0) begin
          t = u % v;
          u = v;
          v = t;
        end
        t = ((n < 0) ? -n : n) / u;
        if ((n < 0) != (d < 0)) begin
          t = -t;
        end
        v = ((d < 0) ? -d : d) / u;
        f.num = t[NUM_W-1:0];
        f.den = v[DEN_W-1:0];
        f.invalid = 1'b0;
      end
      return f;
    endfunction

    function void note_operands(cmd_t op, opnd_t an, opnd_t ad, opnd_t bn, opnd_t bd);
      pending_fractions.push_back(reduce_fraction(op, an, ad, bn, bd));
    endfunction

    function void check_fraction(logic signed [NUM_W-1:0] num, logic [DEN_W-1:0] den,
                                 logic inv);
      fraction_t e;
      if (pending_fractions.size() == 0) begin
        $error("result %0d/%0d invalid %0b with no item pending", num, den, inv);
        mismatches++;
        return;
      end
      e = pending_fractions.pop_front();
      if (num !== e.num) begin
        $error("res_num expected %0d actual %0d", e.num, num);
        mismatches++;
      end
      if (den !== e.den) begin
        $error("res_den expected %0d actual %0d", e.den, den);
        mismatches++;
      end
      if (inv !== e.invalid) begin
        $error("invalid expected %0b actual %0b", e.invalid, inv);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_fractions.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  cmd_t                    in_cmd = CMD_ADD;
  opnd_t                   in_a_num = '0;
  opnd_t                   in_a_den = '0;
  opnd_t                   in_b_num = '0;
  opnd_t                   in_b_den = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [NUM_W-1:0] out_res_num;
  logic [DEN_W-1:0]        out_res_den;
  logic                    out_invalid;

  fraction_checker fractions = new();
  int              cycle_count = 0;
  int              results_seen = 0;
  int              burst_left = 0;

  rational_arith_unit #(
    .OPERAND_WIDTH(OW)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_a_num   (in_a_num),
    .in_a_den   (in_a_den),
    .in_b_num   (in_b_num),
    .in_b_den   (in_b_den),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res_num(out_res_num),
    .out_res_den(out_res_den),
    .out_invalid(out_invalid)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_item(cmd_t op, opnd_t an, opnd_t ad, opnd_t bn, opnd_t bd);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      repeat (gap) @(negedge clk) in_valid = 1'b0;
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_cmd = op;
    in_a_num = an;
    in_a_den = ad;
    in_b_num = bn;
    in_b_den = bd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fractions.note_operands(op, an, ad, bn, bd);
  endtask

  function automatic opnd_t operand_of(int style);
    int v;
    case (style)
      0: v = int'($urandom_range(0, 65535));
      1: v = int'($urandom_range(0, 40)) - 20;
      default: begin
        case ($urandom_range(0, 5))
          0: v = -32768;
          1: v = -32767;
          2: v = -1;
          3: v = 0;
          4: v = 1;
          default: v = 32767;
        endcase
      end
    endcase
    return opnd_t'(v);
  endfunction

  function automatic opnd_t scaled_operand(int k);
    return opnd_t'(k * (int'($urandom_range(0, 362)) - 181));
  endfunction

  task automatic send_random_item();
    int    style, ka, kb;
    cmd_t  op;
    opnd_t an, ad, bn, bd;
    op = cmd_t'($urandom_range(0, 3));
    style = $urandom_range(0, 99);
    if (style < 35) begin
      an = operand_of(0);
      ad = operand_of(0);
      bn = operand_of(0);
      bd = operand_of(0);
    end else if (style < 65) begin
      an = operand_of(1);
      ad = operand_of(1);
      bn = operand_of(1);
      bd = operand_of(1);
    end else if (style < 80) begin
      // shared factors so the reduction has work to do
      ka = $urandom_range(1, 181);
      kb = $urandom_range(1, 181);
      an = scaled_operand(ka);
      ad = scaled_operand(ka);
      bn = scaled_operand(kb);
      bd = scaled_operand(kb);
    end else if (style < 90) begin
      an = operand_of($urandom_range(0, 2));
      ad = operand_of($urandom_range(0, 2));
      bn = operand_of($urandom_range(0, 2));
      bd = operand_of($urandom_range(0, 2));
    end else begin
      an = operand_of(2);
      ad = operand_of(2);
      bn = operand_of(2);
      bd = operand_of(2);
    end
    send_item(op, an, ad, bn, bd);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      fractions.check_fraction(out_res_num, out_res_den, out_invalid);
      results_seen++;
    end
  end

  initial begin : result_sink
    int  mode, span;
    bit  held;
    held = 1'b0;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      if (!held && results_seen >= 300) begin
        // long hold-off so the block backs up into its input
        held = 1'b1;
        @(negedge clk) out_stall = 1'b1;
        repeat (600) @(negedge clk);
      end
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 99) < 30);
          2: out_stall = ($urandom_range(0, 99) < 80);
          default: out_stall = ((cycle_count % 7) < 3);
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("rational_arith_unit test failed");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    send_item(CMD_ADD, 1, 2, 1, 3);
    send_item(CMD_SUB, 1, 2, 1, 2);
    send_item(CMD_MUL, -2, 4, 3, -6);
    send_item(CMD_DIV, 3, 4, 0, -2);
    send_item(CMD_ADD, 5, 0, 1, 3);
    send_item(CMD_SUB, 0, 0, 0, 0);
    send_item(CMD_MUL, 0, 7, 5, 3);
    send_item(CMD_DIV, 0, 7, 5, 3);
    send_item(CMD_ADD, SMIN, SMIN, SMIN, SMIN);
    send_item(CMD_MUL, SMIN, 1, SMIN, 1);
    send_item(CMD_DIV, SMIN, 1, 1, SMIN);
    send_item(CMD_MUL, SMAX, SMIN, SMAX, SMIN);
    send_item(CMD_SUB, SMIN, SMAX, SMAX, SMIN);
    send_item(CMD_ADD, SMIN, SMAX, SMIN, 32765);
    send_item(CMD_DIV, SMAX, SMAX, SMIN, SMIN);
    send_item(CMD_ADD, -1, -1, -1, -1);
    send_item(CMD_SUB, -1, 1, 1, -1);
    send_item(CMD_MUL, -1, 1, 1, 1);
    send_item(CMD_DIV, 1, -1, -1, 1);
    send_item(CMD_DIV, SMIN, SMAX, SMAX, SMIN);
    send_item(CMD_ADD, SMAX, 1, SMAX, 1);
    send_item(CMD_SUB, SMIN, 1, SMAX, 1);
    send_item(CMD_DIV, 6, SMIN, 0, SMIN);
    send_item(CMD_MUL, 16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555);
    send_item(CMD_SUB, 16'shaaaa, 16'sh5555, 16'sh5555, 16'shaaaa);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_random_item();
    end
    @(negedge clk) in_valid = 1'b0;

    while (fractions.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fractions.mismatches == 0) begin
      $display("rational_arith_unit test passed");
    end else begin
      $display("rational_arith_unit test failed");
    end
    $finish;
  end

endmodule
